// ----- rtl/core/smdu_pkg.sv -----
// Package of the signed multiply/divide unit: item types, codes and sizes.
`default_nettype none
package smdu_pkg;
	localparam int TAG_WIDTH = 6;
	localparam int DATA_WIDTH = 64;
	localparam int HALF_WIDTH = DATA_WIDTH / 2;
	localparam int DIV_STEPS = DATA_WIDTH;
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW = $clog2(MQ_DEPTH);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW = $clog2(OQ_DEPTH);

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	localparam logic EXC_NONE = 1'b0;
	localparam logic EXC_DIV_ZERO = 1'b1;

	typedef struct packed {
		logic op;
		logic signed [DATA_WIDTH-1:0] operand_a;
		logic signed [DATA_WIDTH-1:0] operand_b;
		logic [TAG_WIDTH-1:0] dest_tag;
	} req_t;

	typedef struct packed {
		logic [TAG_WIDTH-1:0] result_tag;
		logic [DATA_WIDTH-1:0] result_value;
		logic exception_code;
		logic [3:0] status_flags;
	} rsp_t;

	// Classified item: operands are raw for multiply, magnitudes for divide.
	typedef struct packed {
		logic op;
		logic [TAG_WIDTH-1:0] tag;
		logic neg;
		logic dz;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
	} work_t;

	// One execution pipeline slot; rq holds remainder/quotient or product.
	typedef struct packed {
		logic op;
		logic [TAG_WIDTH-1:0] tag;
		logic neg;
		logic dz;
		logic [DATA_WIDTH-1:0] d;
		logic [2*DATA_WIDTH-1:0] rq;
	} slot_t;
endpackage
`default_nettype wire

// ----- rtl/core/smdu_front.sv -----
// Front end: takes items, classifies them and queues them for execution.
`default_nettype none
module smdu_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire smdu_pkg::req_t req,
	output logic head_valid,
	output smdu_pkg::work_t head,
	input wire logic head_pop
);
	import smdu_pkg::*;

	logic s1_v_q;
	work_t s1_q;
	work_t cls;
	work_t mq_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wptr_q, rptr_q;
	logic [MQ_AW:0] cnt_q;
	logic mq_full, mq_wr, mq_rd, take;

	always_comb begin
		cls.op = req.op;
		cls.tag = req.dest_tag;
		cls.neg = req.operand_a[DATA_WIDTH-1] ^ req.operand_b[DATA_WIDTH-1];
		cls.dz = (req.operand_b == '0);
		if (req.op == OP_DIV) begin
			cls.a = req.operand_a[DATA_WIDTH-1] ? DATA_WIDTH'(-req.operand_a)
				: DATA_WIDTH'(req.operand_a);
			cls.b = req.operand_b[DATA_WIDTH-1] ? DATA_WIDTH'(-req.operand_b)
				: DATA_WIDTH'(req.operand_b);
		end else begin
			cls.a = req.operand_a;
			cls.b = req.operand_b;
		end
	end

	assign mq_full = (cnt_q == (MQ_AW+1)'(MQ_DEPTH));
	assign full = s1_v_q && mq_full;
	assign take = push && !full;
	assign mq_wr = s1_v_q && !mq_full;
	assign head_valid = (cnt_q != '0);
	assign mq_rd = head_pop && head_valid;
	assign head = mq_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				s1_v_q <= 1'b1;
			end else if (mq_wr) begin
				s1_v_q <= 1'b0;
			end
			if (mq_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (mq_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (MQ_AW+1)'(mq_wr) - (MQ_AW+1)'(mq_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_q <= cls;
		end
		if (mq_wr) begin
			mq_q[wptr_q] <= s1_q;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/smdu_back.sv -----
// Back end: pipelined multiplier and radix-2 divider with a result queue.
`default_nettype none
module smdu_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input wire smdu_pkg::work_t head,
	output logic head_pop,
	output logic empty,
	input wire logic pop,
	output smdu_pkg::rsp_t rsp
);
	import smdu_pkg::*;

	function automatic slot_t step(input slot_t s, input int k);
		slot_t r;
		logic [2*DATA_WIDTH-1:0] sh;
		logic [DATA_WIDTH-1:0] hi;
		r = s;
		sh = {s.rq[2*DATA_WIDTH-2:0], 1'b0};
		hi = sh[2*DATA_WIDTH-1:DATA_WIDTH];
		if (s.op == OP_DIV) begin
			if (hi >= s.d) begin
				r.rq = {hi - s.d, sh[DATA_WIDTH-1:1], 1'b1};
			end else begin
				r.rq = sh;
			end
		end else if (k == 1) begin
			// Cross products land in the upper half of the low word.
			r.rq[DATA_WIDTH-1:0] = s.rq[DATA_WIDTH-1:0]
				+ {s.rq[3*HALF_WIDTH-1:2*HALF_WIDTH] + s.rq[4*HALF_WIDTH-1:3*HALF_WIDTH],
				HALF_WIDTH'(0)};
		end
		return r;
	endfunction

	slot_t s0;
	logic s0_v;
	slot_t st [1:DIV_STEPS];
	logic st_v [1:DIV_STEPS];
	logic adv;
	rsp_t fin;
	logic [DATA_WIDTH-1:0] val;
	rsp_t oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] owp_q, orp_q;
	logic [OQ_AW:0] ocnt_q;
	logic o_wr, o_rd;

	assign adv = (ocnt_q != (OQ_AW+1)'(OQ_DEPTH));
	assign head_pop = adv && head_valid;
	assign s0_v = head_valid;

	always_comb begin
		s0.op = head.op;
		s0.tag = head.tag;
		s0.neg = head.neg;
		s0.dz = head.dz;
		s0.d = head.b;
		s0.rq = {DATA_WIDTH'(0), head.a};
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		slot_t cur;
		slot_t nxt;
		logic cur_v;
		if (k == 0) begin : g_first
			assign cur = s0;
			assign cur_v = s0_v;
		end else begin : g_next
			assign cur = st[k];
			assign cur_v = st_v[k];
		end
		always_comb begin
			if (k == 0 && cur.op == OP_MUL) begin
				nxt = cur;
				nxt.rq[DATA_WIDTH-1:0] = cur.rq[HALF_WIDTH-1:0] * cur.d[HALF_WIDTH-1:0];
				nxt.rq[3*HALF_WIDTH-1:2*HALF_WIDTH] = HALF_WIDTH'(
					cur.rq[HALF_WIDTH-1:0] * cur.d[DATA_WIDTH-1:HALF_WIDTH]);
				nxt.rq[4*HALF_WIDTH-1:3*HALF_WIDTH] = HALF_WIDTH'(
					cur.rq[DATA_WIDTH-1:HALF_WIDTH] * cur.d[HALF_WIDTH-1:0]);
			end else begin
				nxt = step(cur, k);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_v[k+1] <= 1'b0;
			end else if (adv) begin
				st_v[k+1] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		if (st[DIV_STEPS].op == OP_MUL) begin
			val = st[DIV_STEPS].rq[DATA_WIDTH-1:0];
		end else if (st[DIV_STEPS].dz) begin
			val = '0;
		end else if (st[DIV_STEPS].neg) begin
			val = '0 - st[DIV_STEPS].rq[DATA_WIDTH-1:0];
		end else begin
			val = st[DIV_STEPS].rq[DATA_WIDTH-1:0];
		end
		fin.result_tag = st[DIV_STEPS].tag;
		fin.result_value = val;
		fin.exception_code = (st[DIV_STEPS].op == OP_DIV && st[DIV_STEPS].dz)
			? EXC_DIV_ZERO : EXC_NONE;
		fin.status_flags = {val[DATA_WIDTH-1], (val == '0), 2'b00};
	end

	assign o_wr = adv && st_v[DIV_STEPS];
	assign empty = (ocnt_q == '0);
	assign o_rd = pop && !empty;
	assign rsp = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0;
			orp_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (o_wr) begin
				owp_q <= owp_q + 1'b1;
			end
			if (o_rd) begin
				orp_q <= orp_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (OQ_AW+1)'(o_wr) - (OQ_AW+1)'(o_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (o_wr) begin
			oq_q[owp_q] <= fin;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/signed_mul_div_unit_core.sv -----
// Top level of the signed 64-bit multiply/divide unit.
//
//  Channel   Handshake      Payload
//  request   push / full    req (op, operand_a, operand_b, dest_tag)
//  result    empty / pop    rsp (result_tag, result_value, exception_code, status_flags)
//
// One item enters per cycle while full is low. Each item passes through the front
// register, the queue and the execution pipeline (one divide step per stage)
// into the result queue, from which its result can be popped.
// Reset empties both queues and the pipeline. When results are not popped the
// pipeline freezes as a whole and the front queue fills before full rises.
`default_nettype none
module signed_mul_div_unit_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire smdu_pkg::req_t req,
	output logic empty,
	input wire logic pop,
	output smdu_pkg::rsp_t rsp
);
	import smdu_pkg::*;

	logic head_valid;
	logic head_pop;
	work_t head;

	smdu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.head_valid(head_valid),
		.head(head),
		.head_pop(head_pop)
	);

	smdu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.head_pop(head_pop),
		.empty(empty),
		.pop(pop),
		.rsp(rsp)
	);
endmodule
`default_nettype wire

// ----- dv/smdu_checker.sv -----
// Checker of the multiply/divide unit: watches both channels, predicts and compares results.
`default_nettype none
module smdu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire smdu_pkg::req_t req,
	input wire logic empty,
	input wire logic pop,
	input wire smdu_pkg::rsp_t rsp,
	output int errors,
	output int pending
);
	import smdu_pkg::*;

	rsp_t expected_results[$];

	function automatic rsp_t compute_result(req_t r);
		rsp_t o;
		logic [DATA_WIDTH-1:0] a, b, mag_a, mag_b, q;
		logic neg;
		a = r.operand_a;
		b = r.operand_b;
		o.result_tag = r.dest_tag;
		o.exception_code = EXC_NONE;
		if (r.op == OP_MUL) begin
			o.result_value = a * b;
		end else if (b == '0) begin
			o.result_value = '0;
			o.exception_code = EXC_DIV_ZERO;
		end else begin
			// Divide magnitudes unsigned, then restore the sign; this makes
			// the most negative value over minus one wrap onto itself.
			neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			mag_a = a[DATA_WIDTH-1] ? -a : a;
			mag_b = b[DATA_WIDTH-1] ? -b : b;
			q = mag_a / mag_b;
			o.result_value = neg ? -q : q;
		end
		o.status_flags = {o.result_value[DATA_WIDTH-1], o.result_value == '0, 2'b00};
		return o;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk) begin
		rsp_t exp_r;
		if (!arst_n)
			errors <= 0;
		if (arst_n && push && !full)
			expected_results.push_back(compute_result(req));
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, rsp);
				errors <= errors + 1;
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp.result_tag !== exp_r.result_tag ||
						rsp.result_value !== exp_r.result_value ||
						rsp.exception_code !== exp_r.exception_code ||
						rsp.status_flags !== exp_r.status_flags) begin
					$display("%0t: expected %p, actual %p", $time, exp_r, rsp);
					errors <= errors + 1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- dv/tb_signed_mul_div_unit_core.sv -----
// Testbench top of the multiply/divide unit: reset, stimulus, verdict.
`default_nettype none
module tb_signed_mul_div_unit_core;
	import smdu_pkg::*;

	localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MINUS_ONE = '1;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	req_t req = '0;
	rsp_t rsp;
	int errors, pending;
	int cycles = 0;
	bit stim_done = 1'b0;

	signed_mul_div_unit_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	smdu_checker i_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp), .errors(errors), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return MIN_VAL;
			1: return MAX_VAL;
			2: return MINUS_ONE;
			3: return '0;
			4: return 64'($urandom_range(0, 20)) - 64'd10;
			5: return {32'($signed($urandom()) >>> 31), $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Unless no_gap is set, waits a random gap, then offers one item until it is accepted.
	task automatic send_item(logic op, logic [63:0] a, logic [63:0] b, logic [5:0] tag,
			bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= '{op: op, operand_a: a, operand_b: b, dest_tag: tag};
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic send_random(bit no_gap);
		logic [63:0] b;
		b = pick_operand();
		// Keep divisors nonzero most of the time so quotients get exercised.
		if ($urandom_range(0, 3) != 0 && b == '0) b = 64'd3;
		send_item(1'($urandom_range(0, 1)), pick_operand(), b, 6'($urandom_range(0, 63)),
			no_gap);
	endtask

	initial begin
		int gap;
		@(negedge clk);
		wait (stim_done);
		forever begin
			gap = (cycles % 3000 < 600) ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stim_done = 1'b1;
		send_item(OP_MUL, MAX_VAL, MAX_VAL, 6'd0, 1'b0);
		send_item(OP_MUL, MIN_VAL, MINUS_ONE, 6'd63, 1'b0);
		send_item(OP_MUL, MIN_VAL, MIN_VAL, 6'h2a, 1'b0);
		send_item(OP_MUL, '0, MINUS_ONE, 6'h15, 1'b0);
		send_item(OP_MUL, MINUS_ONE, MINUS_ONE, 6'd1, 1'b0);
		send_item(OP_MUL, 64'd7, -64'd3, 6'd2, 1'b0);
		send_item(OP_DIV, 64'd100, '0, 6'd3, 1'b0);
		send_item(OP_DIV, '0, '0, 6'd4, 1'b0);
		send_item(OP_DIV, MIN_VAL, '0, 6'd5, 1'b0);
		send_item(OP_DIV, MIN_VAL, MINUS_ONE, 6'd6, 1'b0);
		send_item(OP_DIV, MIN_VAL, 64'd1, 6'd7, 1'b0);
		send_item(OP_DIV, MAX_VAL, MINUS_ONE, 6'd8, 1'b0);
		send_item(OP_DIV, -64'd7, 64'd2, 6'd9, 1'b0);
		send_item(OP_DIV, 64'd7, -64'd2, 6'd10, 1'b0);
		send_item(OP_DIV, -64'd7, -64'd2, 6'd11, 1'b0);
		send_item(OP_DIV, 64'd1, MAX_VAL, 6'd12, 1'b0);
		send_item(OP_DIV, MAX_VAL, MIN_VAL, 6'd13, 1'b0);
		send_item(OP_DIV, MIN_VAL, MIN_VAL, 6'd14, 1'b0);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_random((i % 300) < 60);
		push <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/smdu_pkg.sv
rtl/core/smdu_front.sv
rtl/core/smdu_back.sv
rtl/core/signed_mul_div_unit_core.sv
dv/smdu_checker.sv
dv/tb_signed_mul_div_unit_core.sv
